// ===== rtl/core/lh2srgb_pkg.sv =====
// Types, constants and per-channel conversion functions for the linear half to sRGB8 pixel block.
// The sRGB level table is built at elaboration from exact integer arithmetic.
// No dependencies.
package lh2srgb_pkg;

   localparam int unsigned TexelWidth = 64;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned BigWidth   = 320;

   typedef enum logic {
      FMT_HALF4   = 1'b0,
      FMT_RGB10A2 = 1'b1
   } texel_format_type;

   typedef logic [13:0] level_code_type;
   typedef level_code_type [255:0] level_table_type;

   // value of a normal half code below one, scaled by 2^24
   function automatic logic [23:0] code_value(input logic [13:0] code);
      logic [23:0] mant;
      mant = {13'd0, 1'b1, code[9:0]};
      return mant << (code[13:10] - 4'd1);
   endfunction

   // true when the encoded byte of value v is at least k
   function automatic logic reaches_level(input logic [23:0] v, input logic [7:0] k);
      logic [BigWidth-1:0] lhs;
      logic [BigWidth-1:0] rhs;
      logic [BigWidth-1:0] n;
      logic [63:0]         v64;
      logic [63:0]         k64;
      v64 = 64'(v);
      k64 = 64'(k);
      if (k == 8'd0) begin
         return 1'b1;
      end
      if (v64 * 64'd10000000 <= 64'd31308 * 64'd16777216) begin
         return (64'd32946 * v64) >= ((64'd5 * (64'd2 * k64 - 64'd1)) << 24);
      end
      n   = BigWidth'(64'd40 * k64 + 64'd541);
      lhs = BigWidth'(v);
      for (int i = 0; i < 4; i++) begin
         lhs = lhs * BigWidth'(v);
      end
      for (int i = 0; i < 12; i++) begin
         lhs = lhs * BigWidth'(14'd10761);
      end
      rhs = n;
      for (int i = 0; i < 11; i++) begin
         rhs = rhs * n;
      end
      rhs = rhs << 120;
      return lhs >= rhs;
   endfunction

   // smallest normal half code below one that reaches level k
   function automatic level_code_type level_threshold(input logic [7:0] k);
      logic [14:0] lo;
      logic [14:0] hi;
      logic [14:0] mid;
      lo = 15'h0400;
      hi = 15'h3C00;
      for (int i = 0; i < 15; i++) begin
         if (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (reaches_level(code_value(mid[13:0]), k)) begin
               hi = mid;
            end else begin
               lo = mid + 15'd1;
            end
         end
      end
      return lo[13:0];
   endfunction

   function automatic level_table_type build_level_table();
      level_table_type tbl;
      for (int k = 0; k < 256; k++) begin
         tbl[k] = level_threshold(8'(k));
      end
      return tbl;
   endfunction

   localparam level_table_type SrgbLevel = build_level_table();

   function automatic logic half_is_zero(input logic [15:0] h);
      return h[15] || (h[14:10] == 5'd0) || ((h[14:10] == 5'h1F) && (h[9:0] != 10'd0));
   endfunction

   function automatic logic half_is_full(input logic [15:0] h);
      return !half_is_zero(h) && (h[14:10] >= 5'd15);
   endfunction

   function automatic logic [7:0] srgb_byte(input logic [15:0] h);
      logic [255:0] pass;
      logic [7:0]   k;
      logic [7:0]   probe;
      for (int j = 0; j < 256; j++) begin
         pass[j] = h[13:0] >= SrgbLevel[j];
      end
      k = 8'd0;
      for (int b = 7; b >= 0; b--) begin
         probe = k | (8'd1 << b);
         if (pass[probe]) begin
            k = probe;
         end
      end
      if (half_is_zero(h)) begin
         return 8'd0;
      end
      if (half_is_full(h)) begin
         return 8'hFF;
      end
      return k;
   endfunction

   function automatic logic [7:0] linear_byte(input logic [15:0] h);
      logic [31:0] scaled;
      scaled = 32'(code_value(h[13:0])) * 32'd255 + 32'h0080_0000;
      if (half_is_zero(h)) begin
         return 8'd0;
      end
      if (half_is_full(h)) begin
         return 8'hFF;
      end
      return scaled[31:24];
   endfunction

   // round(255 * q / 1023) as floor((255q + 511) / 1023)
   function automatic logic [7:0] ten_byte(input logic [9:0] q);
      logic [17:0] x;
      logic [28:0] p;
      logic [7:0]  y;
      logic [17:0] rem;
      x   = 18'({8'd0, q} * 18'd255) + 18'd511;
      p   = 29'(x) * 29'd1025;
      y   = p[27:20];
      rem = x - 18'(18'(y) * 18'd1023);
      if (rem >= 18'd1023) begin
         y = y + 8'd1;
      end
      return y;
   endfunction

endpackage

// ===== rtl/core/lh2srgb_if.sv =====
// Valid/ready channel interfaces for texel requests and pixel responses.
// Depends on lh2srgb_pkg.
interface lh2srgb_req_if;
   import lh2srgb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [TexelWidth-1:0] texel_bits;
   modport source (output valid, output texel_bits, input ready);
   modport sink (input valid, input texel_bits, output ready);
endinterface

interface lh2srgb_rsp_if;
   import lh2srgb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] blue_byte;
   logic [ByteWidth-1:0] green_byte;
   logic [ByteWidth-1:0] red_byte;
   logic [ByteWidth-1:0] alpha_byte;
   modport source (output valid, output blue_byte, output green_byte, output red_byte,
                   output alpha_byte, input ready);
   modport sink (input valid, input blue_byte, input green_byte, input red_byte,
                 input alpha_byte, output ready);
endinterface

// ===== rtl/core/linear_half_to_srgb8_pixel.sv =====
// Linear half float or packed 10-10-10-2 texel to 8-bit BGRA pixel.
// Pipeline: input register, then result register, from request beat to response valid.
// Throughput: one beat per cycle unless the output stalls; one registered pass, no loop.
// Reset (synchronous): clears both stage valids and sets the format to four FP16 channels.
// Depends on lh2srgb_pkg and lh2srgb_if.
module linear_half_to_srgb8_pixel (
   input  logic                 clock,
   input  logic                 reset,
   lh2srgb_req_if.sink          req_chan,
   lh2srgb_rsp_if.source        rsp_chan,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import lh2srgb_pkg::*;

   texel_format_type      format_ff;
   logic                  in_valid_ff;
   logic [TexelWidth-1:0] texel_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  out_advance;
   logic                  in_advance;
   logic                  in_valid_in;
   logic [7:0]            blue_ff, green_ff, red_ff, alpha_ff;
   logic [7:0]            blue_in, green_in, red_in, alpha_in;

   assign out_advance  = !out_valid_ff || rsp_chan.ready;
   assign in_advance   = !in_valid_ff || out_advance;
   assign req_chan.ready = in_advance;
   assign in_valid_in  = req_chan.valid ? 1'b1 : (in_valid_ff && !out_advance);
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   always_comb begin
      if (format_ff == FMT_RGB10A2) begin
         blue_in  = ten_byte(texel_ff[29:20]);
         green_in = ten_byte(texel_ff[19:10]);
         red_in   = ten_byte(texel_ff[9:0]);
         alpha_in = {4{texel_ff[31:30]}};
      end else begin
         blue_in  = srgb_byte(texel_ff[47:32]);
         green_in = srgb_byte(texel_ff[31:16]);
         red_in   = srgb_byte(texel_ff[15:0]);
         alpha_in = linear_byte(texel_ff[63:48]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_HALF4;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            format_ff <= texel_format_type'(csr_wr_data);
         end
         if (in_advance) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && in_advance) begin
         texel_ff <= req_chan.texel_bits;
      end
      if (out_advance && in_valid_ff) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         alpha_ff <= alpha_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.blue_byte  = blue_ff;
   assign rsp_chan.green_byte = green_ff;
   assign rsp_chan.red_byte   = red_ff;
   assign rsp_chan.alpha_byte = alpha_ff;

endmodule

// ===== rtl/core/lh2srgb_check.sv =====
// Port-level checks for linear_half_to_srgb8_pixel, attached by bind.
// Depends only on the top level's ports.
module lh2srgb_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel
);
   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel))
      else $error("stalled response beat changed");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> ##2 rsp_valid)
      else $error("response not valid two cycles after request beat");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> pending_ff != 2'd0)
      else $error("response beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more beats in flight than pipeline stages");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind linear_half_to_srgb8_pixel lh2srgb_check u_lh2srgb_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_pixel ({rsp_chan.alpha_byte, rsp_chan.red_byte, rsp_chan.green_byte,
                rsp_chan.blue_byte})
);

// ===== verif/lh2srgb_pixel_scoreboard.sv =====
// Scoreboard for linear_half_to_srgb8_pixel: watches the texel and pixel channels and the
// format register port, predicts each BGRA pixel with exact integer math and compares.
// Depends on lh2srgb_pkg and lh2srgb_if.
module lh2srgb_pixel_scoreboard (
   input  logic   clock,
   input  logic   reset,
   lh2srgb_req_if req_tap,
   lh2srgb_rsp_if rsp_tap,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data,
   output int     fail_count,
   output int     pending_pixels
);
   timeunit 1ns;
   timeprecision 1ps;
   import lh2srgb_pkg::*;

   typedef struct packed {
      logic [ByteWidth-1:0] blue;
      logic [ByteWidth-1:0] green;
      logic [ByteWidth-1:0] red;
      logic [ByteWidth-1:0] alpha;
   } bgra_pixel_type;

   bgra_pixel_type   expected_pixels[$];
   texel_format_type active_format = FMT_HALF4;
   int               mismatches = 0;

   // half code to x * 2^24 for 0 <= x < 1; saturated marks x >= 1
   function automatic bit [23:0] half_fraction(input bit [15:0] code, output bit saturated);
      bit [4:0] expo;
      bit [9:0] frac;
      expo      = code[14:10];
      frac      = code[9:0];
      saturated = 1'b0;
      if (code[15] || expo == 5'd0) begin
         return 24'd0;
      end
      if (expo == 5'd31) begin
         saturated = (frac == 10'd0);
         return 24'd0;
      end
      if (expo >= 5'd15) begin
         saturated = 1'b1;
         return 24'd0;
      end
      return 24'({1'b1, frac}) << (expo - 5'd1);
   endfunction

   // true when the sRGB encode of lin reaches byte level
   function automatic bit srgb_at_least(input bit [23:0] lin, input bit [7:0] level);
      bit [319:0] power_side;
      bit [319:0] level_side;
      bit [319:0] level_base;
      bit [63:0]  lin_w;
      bit [63:0]  level_w;
      lin_w   = 64'(lin);
      level_w = 64'(level);
      if (level == 8'd0) begin
         return 1'b1;
      end
      if (lin_w * 64'd10000000 <= 64'd31308 * 64'd16777216) begin
         return 64'd32946 * lin_w >= ((64'd5 * (64'd2 * level_w - 64'd1)) << 24);
      end
      level_base = 320'(64'd40 * level_w + 64'd541);
      power_side = 320'd1;
      for (int i = 0; i < 5; i++) begin
         power_side = power_side * 320'(lin);
      end
      for (int i = 0; i < 12; i++) begin
         power_side = power_side * 320'd10761;
      end
      level_side = 320'd1;
      for (int i = 0; i < 12; i++) begin
         level_side = level_side * level_base;
      end
      return power_side >= (level_side << 120);
   endfunction

   function automatic bit [7:0] encode_srgb(input bit [15:0] code);
      bit [23:0] lin;
      bit        saturated;
      bit [7:0]  level;
      lin   = half_fraction(code, saturated);
      level = 8'd0;
      if (saturated) begin
         return 8'hFF;
      end
      for (int b = 7; b >= 0; b--) begin
         if (srgb_at_least(lin, level | (8'd1 << b))) begin
            level = level | (8'd1 << b);
         end
      end
      return level;
   endfunction

   function automatic bit [7:0] encode_alpha(input bit [15:0] code);
      bit [23:0] lin;
      bit        saturated;
      bit [63:0] scaled;
      lin    = half_fraction(code, saturated);
      scaled = (64'(lin) * 64'd255 + 64'd8388608) >> 24;
      if (saturated) begin
         return 8'hFF;
      end
      return scaled[7:0];
   endfunction

   function automatic bit [7:0] scale_ten(input bit [9:0] q);
      int unsigned wide;
      wide = (510 * int'(q) + 1023) / 2046;
      return wide[7:0];
   endfunction

   function automatic bgra_pixel_type predict_pixel(input logic [TexelWidth-1:0] texel,
                                                    input texel_format_type fmt);
      bgra_pixel_type px;
      if (fmt == FMT_HALF4) begin
         px.blue  = encode_srgb(texel[47:32]);
         px.green = encode_srgb(texel[31:16]);
         px.red   = encode_srgb(texel[15:0]);
         px.alpha = encode_alpha(texel[63:48]);
      end else begin
         px.blue  = scale_ten(texel[29:20]);
         px.green = scale_ten(texel[19:10]);
         px.red   = scale_ten(texel[9:0]);
         px.alpha = 8'(8'd85 * 8'(texel[31:30]));
      end
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_byte(input string field, input logic [7:0] got,
                               input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s byte got %0h, expected %0h", field, got, want));
      end
   endtask

   always @(posedge clock) begin
      bgra_pixel_type want;
      bgra_pixel_type got;
      if (reset) begin
         expected_pixels.delete();
         active_format = FMT_HALF4;
      end else begin
         if (rsp_tap.valid && rsp_tap.ready) begin
            got = {rsp_tap.blue_byte, rsp_tap.green_byte, rsp_tap.red_byte, rsp_tap.alpha_byte};
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel beat %0h with no pixel expected", got));
            end else begin
               want = expected_pixels.pop_front();
               compare_byte("blue", got.blue, want.blue);
               compare_byte("green", got.green, want.green);
               compare_byte("red", got.red, want.red);
               compare_byte("alpha", got.alpha, want.alpha);
            end
         end
         if (req_tap.valid && req_tap.ready) begin
            expected_pixels.push_back(predict_pixel(req_tap.texel_bits, active_format));
         end
         if (csr_wr_en) begin
            active_format = texel_format_type'(csr_wr_data);
         end
      end
      fail_count     <= mismatches;
      pending_pixels <= expected_pixels.size();
   end

endmodule

// ===== verif/tb_linear_half_to_srgb8_pixel.sv =====
// Top of the linear_half_to_srgb8_pixel testbench: clock, reset, texel stimulus in both
// formats, a stalling pixel receiver and the verdict. Depends on lh2srgb_pkg, lh2srgb_if,
// lh2srgb_pixel_scoreboard and the block itself.
module tb_linear_half_to_srgb8_pixel;
   timeunit 1ns;
   timeprecision 1ps;
   import lh2srgb_pkg::*;

   localparam logic [15:0] CornerHalves [16] = '{
      16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400, 16'h1A69, 16'h1A6A, 16'h2E00,
      16'h3800, 16'h3BFF, 16'h3C00, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01
   };

   localparam logic [63:0] PackedDirected [8] = '{
      64'h0,
      64'hFFFF_FFFF_FFFF_FFFF,
      {32'h0000_0000, 2'd1, 10'd1, 10'd511, 10'd512},
      {32'hFFFF_FFFF, 2'd2, 10'd1022, 10'd0, 10'd1023},
      {32'h5555_AAAA, 2'd3, 10'd512, 10'd1, 10'd511},
      {32'h0000_0000, 2'd0, 10'd1023, 10'd1023, 10'd0},
      {32'hAAAA_5555, 2'd1, 10'h155, 10'h2AA, 10'h155},
      {32'h0000_0000, 2'd2, 10'd2, 10'd1021, 10'd3}
   };

   localparam logic [9:0] TenCorners [6] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd1022, 10'd1023};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   logic stall_toggle;
   int   fail_count;
   int   pending_pixels;

   texel_format_type stim_format;

   lh2srgb_req_if req_chan ();
   lh2srgb_rsp_if rsp_chan ();

   linear_half_to_srgb8_pixel dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lh2srgb_pixel_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tap        (req_chan),
      .rsp_tap        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .pending_pixels (pending_pixels)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [15:0] pick_half();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         return 16'($urandom_range(16'h0400, 16'h3BFF));
      end
      if (sel < 65) begin
         return 16'($urandom_range(16'h0400, 16'h1C00));
      end
      if (sel < 80) begin
         return 16'($urandom);
      end
      return CornerHalves[$urandom_range(0, 15)];
   endfunction

   function automatic logic [63:0] pick_texel(input texel_format_type fmt);
      if (fmt == FMT_HALF4) begin
         return {pick_half(), pick_half(), pick_half(), pick_half()};
      end
      if ($urandom_range(0, 3) == 0) begin
         return {32'($urandom), 2'($urandom), TenCorners[$urandom_range(0, 5)],
                 TenCorners[$urandom_range(0, 5)], TenCorners[$urandom_range(0, 5)]};
      end
      return {32'($urandom), 32'($urandom)};
   endfunction

   task automatic send_texel(input logic [63:0] texel);
      req_chan.valid      <= 1'b1;
      req_chan.texel_bits <= texel;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         req_chan.valid      <= 1'b0;
         req_chan.texel_bits <= {32'($urandom), 32'($urandom)};
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_format(input texel_format_type fmt);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stim_format = fmt;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input bit with_holdoff);
      int  sent;
      int  burst;
      bit  held;
      bit  paused;
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < count) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_texel(pick_texel(stim_format));
            sent++;
         end
         if (with_holdoff && !held && sent >= count / 3) begin
            // hold the receiver off and keep offering beats so that the input stalls
            stall_toggle <= ~stall_toggle;
            for (int i = 0; i < 40; i++) begin
               send_texel(pick_texel(stim_format));
               sent++;
            end
            held = 1'b1;
         end
         if (!paused && sent >= count / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      end
   endtask

   // receiver: switches among four stall patterns at random, long hold-off on request
   initial begin
      int          hold_left;
      int          mode_left;
      int unsigned tick;
      logic        seen_toggle;
      logic [1:0]  ready_mode;
      hold_left   = 0;
      mode_left   = 0;
      tick        = 0;
      seen_toggle = 1'b0;
      ready_mode  = 2'd0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall_toggle != seen_toggle) begin
            seen_toggle = stall_toggle;
            hold_left   = 150;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = 2'($urandom_range(0, 3));
               mode_left  = $urandom_range(16, 96);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               2'd0: begin
                  rsp_chan.ready <= 1'b1;
               end
               2'd1: begin
                  rsp_chan.ready <= 1'($urandom_range(0, 1));
               end
               2'd2: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_chan.ready <= tick[2];
               end
            endcase
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= 1'b0;
      stall_toggle        <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.texel_bits <= '0;
      stim_format = FMT_HALF4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_format(FMT_HALF4);
      for (int i = 0; i < 16; i++) begin
         send_texel({CornerHalves[i], CornerHalves[(i + 5) % 16],
                     CornerHalves[(i + 10) % 16], CornerHalves[(i + 3) % 16]});
      end
      set_format(FMT_RGB10A2);
      for (int i = 0; i < 8; i++) begin
         send_texel(PackedDirected[i]);
         idle_for($urandom_range(0, 2));
      end

      for (int phase = 0; phase < 8; phase++) begin
         if (phase % 2 == 0) begin
            set_format(FMT_HALF4);
            random_phase(180, phase == 2);
         end else begin
            set_format(FMT_RGB10A2);
            random_phase(70, phase == 5);
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_pixels == 0) begin
         $display("linear_half_to_srgb8_pixel test passed");
      end else begin
         $display("linear_half_to_srgb8_pixel test failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("linear_half_to_srgb8_pixel test failed");
      $finish;
   end

endmodule
